// ===== rtl/chm_pkg.sv =====
// chm_pkg: shared constants for the coalesced hash map.
// No dependencies.
package chm_pkg;
    localparam int unsigned CAPACITY_DEF = 256;
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
endpackage

// ===== rtl/coalesced_hash_map.sv =====
// coalesced_hash_map: coalesced-hashing key/value map, table in one RAM.
// Depends on chm_pkg.
//
// An op walks the chain from its home slot; an insert may then probe the free
// pointer past used slots (after relinking the chain tail), and a remove
// examines the chain after the hit, relocates entries homed at the hole, then
// scans the whole table for the predecessor and unlinks the hole.
// One transaction at a time: o_ready returns the cycle after the
// result is taken.
// Reset: synchronous; afterwards a clearing pass zeroes keys, values and used
// bits and sets every link to null while o_ready stays low.
module coalesced_hash_map #(
    parameter int unsigned CAPACITY = chm_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic [8:0]         o_entry_count
);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned LW = AW + 1;        // link incl. null
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);
    localparam int unsigned EW = 32 + 32 + LW + 1;

    // state codes
    localparam logic [4:0] S_CLR   = 5'd0,  S_IDLE  = 5'd1,  S_HASH  = 5'd2,
                           S_RD    = 5'd3,  S_CHK   = 5'd4,  S_FREE  = 5'd5,
                           S_FCHK  = 5'd6,  S_OUT   = 5'd7,  S_RMV   = 5'd8,
                           S_RMCHK = 5'd9,  S_RMHM  = 5'd10, S_RMMOV = 5'd11,
                           S_PSCAN = 5'd12, S_PCHK  = 5'd13, S_VAC   = 5'd14,
                           S_TAILW = 5'd15;

    // one table entry: key, value, link, used
    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    // memory write requests are issued from the sequential block via regs
    logic          r_we;
    logic [AW-1:0] r_wa;
    logic [EW-1:0] r_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    logic [31:0]   rd_key, rd_val;
    logic [LW-1:0] rd_nxt;
    logic          rd_used;
    assign {rd_key, rd_val, rd_nxt, rd_used} = r_rd;

    logic [4:0]    r_st;
    logic [1:0]    r_mode;
    logic [31:0]   r_key, r_val, r_vout, r_mkey, r_mval;
    logic [AW-1:0] r_home, r_cur, r_tail, r_hole, r_scan;
    logic [LW-1:0] r_fp, r_cnt, r_hnext, r_j;
    logic [AW:0]   r_clr;
    logic [2:0]    r_status;
    logic          r_ovalid, r_pfound;
    logic [31:0]   mag;
    logic [AW-1:0] home_rd;

    // home slot: |key| mod CAPACITY (power-of-two capacity assumed)
    assign mag     = r_key[31] ? (32'd0 - r_key) : r_key;
    assign home_rd = AW'(((rd_key[31] ? (32'd0 - rd_key) : rd_key)) % CAPACITY);

    always_comb begin
        mem_we = r_we; mem_wa = r_wa; mem_wd = r_wd; mem_ra = r_cur;
        unique case (r_st)
            S_CLR: begin
                mem_we = 1'b1; mem_wa = r_clr[AW-1:0];
                mem_wd = {64'd0, NIL, 1'b0};
            end
            S_PSCAN: mem_ra = r_scan;
            S_FREE:  mem_ra = r_fp[AW-1:0];
            default: mem_ra = r_cur;
        endcase
    end

    assign o_ready       = (r_st == S_IDLE) && !r_ovalid;
    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_value_out   = r_vout;
    assign o_entry_count = 9'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_ovalid <= 1'b0;
            r_fp <= '0; r_cnt <= '0; r_we <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(CAPACITY - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_valid && o_ready) begin
                    r_mode <= i_mode; r_key <= i_key; r_val <= i_value;
                    r_vout <= '0; r_status <= chm_pkg::ST_NOTFOUND;
                    r_st <= (i_mode == chm_pkg::MODE_NOP) ? S_OUT : S_HASH;
                end
                S_HASH: begin
                    r_home <= AW'(mag % CAPACITY);
                    r_cur  <= AW'(mag % CAPACITY);
                    r_st   <= S_RD;
                end
                S_RD: r_st <= S_CHK;       // read in flight
                S_CHK: begin
                    if (r_cur == r_home && !rd_used) begin
                        if (r_mode == chm_pkg::MODE_INSERT) begin
                            r_we <= 1'b1; r_wa <= r_home;
                            r_wd <= {r_key, r_val, NIL, 1'b1};
                            r_cnt <= r_cnt + 1'b1;
                            r_status <= chm_pkg::ST_ADDED;
                            if (LW'(r_home) == r_fp) begin
                                r_fp <= r_fp + 1'b1; r_st <= S_FREE;
                            end else r_st <= S_OUT;
                        end else r_st <= S_OUT;
                    end else if (rd_used && rd_key == r_key) begin
                        r_vout <= rd_val;
                        unique case (r_mode)
                            chm_pkg::MODE_INSERT: begin
                                r_we <= 1'b1; r_wa <= r_cur;
                                r_wd <= {rd_key, r_val, rd_nxt, 1'b1};
                                r_status <= chm_pkg::ST_REPLACED;
                                r_st <= S_OUT;
                            end
                            chm_pkg::MODE_LOOKUP: begin
                                r_status <= chm_pkg::ST_FOUND; r_st <= S_OUT;
                            end
                            default: begin
                                r_cnt <= r_cnt - 1'b1;
                                r_hole <= r_cur; r_hnext <= rd_nxt;
                                r_j <= rd_nxt; r_st <= S_RMV;
                            end
                        endcase
                    end else if (rd_nxt >= NIL) begin
                        if (r_mode == chm_pkg::MODE_INSERT) begin
                            r_tail <= r_cur;
                            if (r_fp >= NIL) begin
                                r_status <= chm_pkg::ST_FULL; r_st <= S_OUT;
                            end else begin
                                r_we <= 1'b1; r_wa <= r_fp[AW-1:0];
                                r_wd <= {r_key, r_val, NIL, 1'b1};
                                r_cnt <= r_cnt + 1'b1;
                                r_status <= chm_pkg::ST_ADDED;
                                r_cur <= r_cur; r_st <= S_TAILW;
                            end
                        end else r_st <= S_OUT;
                    end else begin
                        r_cur <= rd_nxt[AW-1:0]; r_st <= S_RD;
                    end
                end
                S_TAILW: begin
                    // link old tail to new slot (tail data in r_rd still)
                    r_we <= 1'b1; r_wa <= r_tail;
                    r_wd <= {rd_key, rd_val, r_fp, rd_used};
                    r_fp <= r_fp + 1'b1; r_st <= S_FREE;
                end
                S_FREE: begin
                    // advance free pointer past used slots
                    if (r_fp >= NIL) r_st <= S_OUT;
                    else r_st <= S_FCHK;
                end
                S_FCHK: begin
                    if (rd_used) begin r_fp <= r_fp + 1'b1; r_st <= S_FREE; end
                    else r_st <= S_OUT;
                end
                S_RMV: begin
                    // search chain from hole's successor for home == hole
                    if (r_j >= NIL) begin
                        r_scan <= '0; r_pfound <= 1'b0; r_st <= S_PSCAN;
                    end else begin
                        r_cur <= r_j[AW-1:0]; r_st <= S_RMCHK;
                    end
                end
                S_RMCHK: r_st <= S_RMHM;
                S_RMHM: begin
                    if (home_rd == r_hole) begin
                        r_mkey <= rd_key; r_mval <= rd_val; r_st <= S_RMMOV;
                    end else begin
                        r_j <= rd_nxt; r_st <= S_RMV;
                    end
                end
                S_RMMOV: begin
                    // move entry j into hole; j becomes the new hole
                    r_we <= 1'b1; r_wa <= r_hole;
                    r_wd <= {r_mkey, r_mval, r_hnext, 1'b1};
                    r_hole <= r_cur; r_hnext <= rd_nxt; r_j <= rd_nxt;
                    r_st <= S_RMV;
                end
                S_PSCAN: r_st <= S_PCHK;
                S_PCHK: begin
                    if (!r_pfound && r_scan != r_hole && rd_used &&
                        rd_nxt == LW'(r_hole)) begin
                        r_pfound <= 1'b1;
                        r_we <= 1'b1; r_wa <= r_scan;
                        r_wd <= {rd_key, rd_val, r_hnext, 1'b1};
                    end
                    if (LW'(r_scan) == NIL - 1'b1) r_st <= S_VAC;
                    else begin r_scan <= r_scan + 1'b1; r_st <= S_PSCAN; end
                end
                S_VAC: begin
                    r_we <= 1'b1; r_wa <= r_hole;
                    r_wd <= {64'd0, NIL, 1'b0};
                    r_status <= chm_pkg::ST_REMOVED; r_st <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // Results hold until taken, S_OUT always yields one, count stays <= CAPACITY.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_status))
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_OUT |=> r_ovalid)
        else $error("no result after op");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NIL)
        else $error("count overflow");
endmodule

// ===== verif/coalesced_hash_map_tb.sv =====
// coalesced_hash_map_tb: self-checking testbench for the coalesced hash map.
// Depends on chm_pkg and coalesced_hash_map; scoreboard predicts every result.
`timescale 1ns / 100ps

module coalesced_hash_map_tb;
    localparam int unsigned CAP = chm_pkg::CAPACITY_DEF;
    localparam int unsigned NIL = CAP;
    localparam int unsigned N_RANDOM = 1230;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
    } op_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
        logic [8:0]  entry_count;
    } answer_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_mode;
    logic signed [31:0] i_key;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_ready;
    logic [2:0]         o_status;
    logic signed [31:0] o_value_out;
    logic [8:0]         o_entry_count;

    coalesced_hash_map dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_value_out  (o_value_out),
        .o_entry_count(o_entry_count)
    );

    // Shadow copy of the table.
    logic [31:0] tbl_key   [CAP];
    logic [31:0] tbl_value [CAP];
    int unsigned tbl_next  [CAP];
    bit          tbl_used  [CAP];
    int unsigned n_entries;
    int unsigned free_ptr;

    op_t     pending_ops[$];
    answer_t expected_answers[$];
    logic [31:0] live_keys[$];   // keys inserted at some point, for reuse
    int unsigned n_mismatch;
    int unsigned n_checked;
    int unsigned n_sent;
    int unsigned n_full;
    int unsigned n_removed;
    int unsigned cycle_no;
    bit          stim_done;

    function automatic int unsigned home_slot(logic [31:0] k);
        logic [31:0] mag;
        mag = k[31] ? (32'd0 - k) : k;
        return mag % CAP;
    endfunction

    function automatic void bump_free();
        free_ptr++;
        while (free_ptr < CAP && tbl_used[free_ptr]) free_ptr++;
    endfunction

    function automatic int unsigned find_slot(logic [31:0] k, int unsigned h);
        int unsigned i;
        i = h;
        if (!tbl_used[h]) return NIL;
        for (int s = 0; s <= CAP; s++) begin
            if (tbl_used[i] && tbl_key[i] == k) return i;
            if (tbl_next[i] >= NIL) return NIL;
            i = tbl_next[i];
        end
        return NIL;
    endfunction

    // Apply one transaction to the shadow table and return its answer.
    function automatic answer_t apply_op(op_t op);
        answer_t a;
        int unsigned h, i, tail, pos, j, st;
        bit hit;
        h = home_slot(op.key);
        a.status = chm_pkg::ST_NOTFOUND;
        a.value_out = '0;
        case (op.mode)
            chm_pkg::MODE_INSERT: begin
                if (!tbl_used[h]) begin
                    tbl_key[h] = op.key;
                    tbl_value[h] = op.value;
                    tbl_next[h] = NIL;
                    tbl_used[h] = 1;
                    n_entries++;
                    if (h == free_ptr) bump_free();
                    a.status = chm_pkg::ST_ADDED;
                end else begin
                    i = h;
                    tail = h;
                    hit = 0;
                    for (int s = 0; s <= CAP; s++) begin
                        if (tbl_used[i] && tbl_key[i] == op.key) begin
                            hit = 1;
                            break;
                        end
                        tail = i;
                        if (tbl_next[i] >= NIL) break;
                        i = tbl_next[i];
                    end
                    if (hit) begin
                        a.value_out = tbl_value[i];
                        tbl_value[i] = op.value;
                        a.status = chm_pkg::ST_REPLACED;
                    end else if (free_ptr >= CAP) begin
                        a.status = chm_pkg::ST_FULL;
                    end else begin
                        tbl_key[free_ptr] = op.key;
                        tbl_value[free_ptr] = op.value;
                        tbl_next[free_ptr] = NIL;
                        tbl_used[free_ptr] = 1;
                        tbl_next[tail] = free_ptr;
                        n_entries++;
                        bump_free();
                        a.status = chm_pkg::ST_ADDED;
                    end
                end
            end
            chm_pkg::MODE_LOOKUP: begin
                pos = find_slot(op.key, h);
                if (pos < NIL) begin
                    a.value_out = tbl_value[pos];
                    a.status = chm_pkg::ST_FOUND;
                end
            end
            chm_pkg::MODE_REMOVE: begin
                pos = find_slot(op.key, h);
                if (pos < NIL) begin
                    a.value_out = tbl_value[pos];
                    n_entries--;
                    i = pos;
                    // Pull later chain members homed at the hole into it.
                    for (int o = 0; o <= CAP; o++) begin
                        j = tbl_next[i];
                        st = 0;
                        while (j < NIL && home_slot(tbl_key[j]) != i && st <= CAP) begin
                            j = tbl_next[j];
                            st++;
                        end
                        if (j >= NIL || home_slot(tbl_key[j]) != i) break;
                        tbl_key[i] = tbl_key[j];
                        tbl_value[i] = tbl_value[j];
                        i = j;
                    end
                    // Unlink the final hole from whichever slot points at it.
                    for (int p = 0; p < CAP; p++) begin
                        if (p != i && tbl_used[p] && tbl_next[p] == i) begin
                            tbl_next[p] = tbl_next[i];
                            break;
                        end
                    end
                    tbl_next[i] = NIL;
                    tbl_used[i] = 0;
                    tbl_key[i] = '0;
                    tbl_value[i] = '0;
                    a.status = chm_pkg::ST_REMOVED;
                end
            end
            default: ;
        endcase
        a.entry_count = n_entries[8:0];
        return a;
    endfunction

    function automatic void queue_op(logic [1:0] m, logic [31:0] k, logic [31:0] v);
        op_t op;
        op.mode = m;
        op.key = k;
        op.value = v;
        pending_ops.push_back(op);
        if (m == chm_pkg::MODE_INSERT) live_keys.push_back(k);
    endfunction

    // Key mostly reused or from 48 crowded homes so chains grow long and coalesce.
    function automatic logic [31:0] pick_key();
        int unsigned r;
        logic [31:0] k;
        r = $urandom_range(0, 99);
        if (r < 45 && live_keys.size() > 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if (r < 85) begin
            k = $urandom_range(0, 15) * CAP + $urandom_range(0, 47);
            if ($urandom_range(0, 1)) k = 32'd0 - k;
            return k;
        end
        k = $urandom;
        if (k == 32'h8000_0000 && $urandom_range(0, 1)) k = 32'h7fff_ffff;
        return k;
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_no <= cycle_no + 1;

    // Idle pattern: ~26% random gaps, none strictly between cycles 3000 and 6000.
    function automatic bit take_gap();
        if (cycle_no > 3000 && cycle_no < 6000) return 0;
        return $urandom_range(0, 99) < 26;
    endfunction

    // Driver: present the next pending transaction, hold it until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                expected_answers.push_back(apply_op({i_mode, i_key, i_value}));
                n_sent++;
            end
            if (pending_ops.size() > 0 && !take_gap()) begin
                op_t op;
                op = pending_ops.pop_front();
                i_valid <= 1'b1;
                i_mode <= op.mode;
                i_key <= op.key;
                i_value <= op.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_answers.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result: status=%0d value=%0d count=%0d",
                                 o_status, o_value_out, o_entry_count);
                end else begin
                    answer_t exp_a;
                    exp_a = expected_answers.pop_front();
                    n_checked++;
                    if (exp_a.status == chm_pkg::ST_FULL) n_full++;
                    if (exp_a.status == chm_pkg::ST_REMOVED) n_removed++;
                    if (o_status !== exp_a.status || o_value_out !== exp_a.value_out ||
                        o_entry_count !== exp_a.entry_count) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch #%0d: exp st=%0d val=%0d cnt=%0d, got st=%0d val=%0d cnt=%0d",
                                     n_checked, exp_a.status, $signed(exp_a.value_out),
                                     exp_a.entry_count, o_status, o_value_out, o_entry_count);
                    end
                end
            end
            i_ready <= !take_gap();
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_mode = chm_pkg::MODE_INSERT;
        i_key = '0;
        i_value = '0;
        cycle_no = 0;
        n_mismatch = 0;
        n_checked = 0;
        n_sent = 0;
        n_full = 0;
        n_removed = 0;
        n_entries = 0;
        free_ptr = 0;
        stim_done = 0;
        for (int s = 0; s < CAP; s++) begin
            tbl_key[s] = '0;
            tbl_value[s] = '0;
            tbl_next[s] = NIL;
            tbl_used[s] = 0;
        end

        // Directed: empty-table ops, field extremes, collisions, no-op mode.
        queue_op(chm_pkg::MODE_LOOKUP, 32'd5, 32'd0);
        queue_op(chm_pkg::MODE_REMOVE, 32'd5, 32'd0);
        queue_op(chm_pkg::MODE_INSERT, 32'h8000_0000, 32'h8000_0000);   // magnitude 2^31
        queue_op(chm_pkg::MODE_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_op(chm_pkg::MODE_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        queue_op(chm_pkg::MODE_INSERT, 32'd1, 32'd11);                  // collides with -1
        queue_op(chm_pkg::MODE_INSERT, 32'd0, 32'd0);
        queue_op(chm_pkg::MODE_INSERT, 32'd256, 32'd22);                // chain on home 0
        queue_op(chm_pkg::MODE_INSERT, 32'd512, 32'd33);
        queue_op(chm_pkg::MODE_INSERT, 32'd2, 32'd44);                  // home taken by chain
        queue_op(chm_pkg::MODE_INSERT, 32'd256, 32'h5555_aaaa);         // replace
        queue_op(chm_pkg::MODE_LOOKUP, 32'd512, 32'd0);
        queue_op(chm_pkg::MODE_LOOKUP, 32'h8000_0000, 32'd0);
        queue_op(chm_pkg::MODE_LOOKUP, 32'd768, 32'd0);
        queue_op(chm_pkg::MODE_NOP, 32'd1, 32'd99);                     // no-op mode
        queue_op(chm_pkg::MODE_REMOVE, 32'd0, 32'd0);                   // removes mid-chain; 256 stays in its slot
        queue_op(chm_pkg::MODE_LOOKUP, 32'd256, 32'd0);
        queue_op(chm_pkg::MODE_REMOVE, 32'd1, 32'd0);
        queue_op(chm_pkg::MODE_REMOVE, 32'd1, 32'd0);
        queue_op(chm_pkg::MODE_LOOKUP, 32'd2, 32'd0);
        queue_op(chm_pkg::MODE_REMOVE, 32'h8000_0000, 32'd0);

        // Random phases; a fill phase in the middle drives the table full.
        for (int n = 0; n < N_RANDOM; n++) begin
            int unsigned r;
            logic [1:0] m;
            r = $urandom_range(0, 99);
            if (n >= 400 && n < 800)
                m = (r < 85) ? chm_pkg::MODE_INSERT :
                    (r < 95 ? chm_pkg::MODE_LOOKUP : chm_pkg::MODE_REMOVE);
            else if (n >= 1000)
                m = (r < 60) ? chm_pkg::MODE_REMOVE :
                    (r < 80 ? chm_pkg::MODE_LOOKUP : chm_pkg::MODE_INSERT);
            else
                m = (r < 45) ? chm_pkg::MODE_INSERT : (r < 70 ? chm_pkg::MODE_LOOKUP :
                    (r < 97 ? chm_pkg::MODE_REMOVE : chm_pkg::MODE_NOP));
            queue_op(m, pick_key(), $urandom);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && !i_valid);
        wait (expected_answers.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("Checked %0d of %0d transactions (%0d removes, %0d table-full).",
                 n_checked, n_sent, n_removed, n_full);
        if (n_mismatch == 0 && expected_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Worst case: each remove that hits scans the whole table, plus stalls.
    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", expected_answers.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
